@@ design/rect_blit_fill_engine_top_macros.svh @@
// Assertion macros for the rectangle engine's RTL, used by the pixel engine.
`ifndef RECT_BLIT_FILL_ENGINE_TOP_MACROS_SVH
`define RECT_BLIT_FILL_ENGINE_TOP_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RBF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define RBF_ASSERT(label, prop, msg) \
  `RBF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ design/rbf_pkg.sv @@
// Package with the types and constants of the rectangle copy and fill engine.
`default_nettype none

package rbf_pkg;

  // Widths fixed by the item format.
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STRIDE_W  = 13;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned DIM_IN_W  = 13;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned OFF_W     = STRIDE_W + COORD_W + 1;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 96;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_DIM_DEFAULT     = 4096;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Byte-mode fill mask.
  localparam logic [COLOR_W-1:0] BYTE_MASK = 32'h0000_00ff;

  // Configuration register byte address bit that selects the register index.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_PIXEL_SIZE = 1'b0;

  // Item kinds on the input side.
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_BLIT = 2'd1,
    KIND_FILL = 2'd2
  } rbf_kind_e;

  // Access kinds on the output side.
  typedef enum logic {
    ACCESS_COPY = 1'b0,
    ACCESS_FILL = 1'b1
  } rbf_access_e;

  // One classified command between the front end and the pixel engine.
  typedef struct packed {
    rbf_kind_e             kind;
    logic [ADDR_W-1:0]     src_base;
    logic [ADDR_W-1:0]     dst_base;
    logic [STRIDE_W-1:0]   src_stride;
    logic [STRIDE_W-1:0]   dst_stride;
    logic [OFF_W-1:0]      src_off;
    logic [OFF_W-1:0]      dst_off;
    logic [DIM_IN_W-1:0]   width;
    logic [DIM_IN_W-1:0]   height;
    logic [COLOR_W-1:0]    color;
  } rbf_cmd_t;

endpackage

`default_nettype wire

@@ design/rbf_front.sv @@
// Front end: accepts items, drops unused kinds and forms pixel offsets of the corners.
`default_nettype none

module rbf_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [rbf_pkg::KIND_W-1:0]  in_kind_i,
  input  wire logic [rbf_pkg::IN_DATA_W-1:0] in_data_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output rbf_pkg::rbf_cmd_t                push_cmd_o
);
  import rbf_pkg::*;

  logic                  vld_q, vld_d;
  rbf_kind_e             kind_q;
  logic [ADDR_W-1:0]     src_base_q, dst_base_q;
  logic [STRIDE_W-1:0]   src_stride_q, dst_stride_q;
  logic [COORD_W-1:0]    src_x_q, dst_x_q;
  logic [OFF_W-2:0]      src_prod_q, dst_prod_q;
  logic [DIM_IN_W-1:0]   width_q, height_q;
  logic [COLOR_W-1:0]    color_q;

  logic                  accept;
  logic                  keep;
  rbf_kind_e             in_kind;

  // Unpack the input fields.
  logic [ADDR_W-1:0]     f_src_base, f_dst_base;
  logic [STRIDE_W-1:0]   f_src_stride, f_dst_stride;
  logic [COORD_W-1:0]    f_src_x, f_src_y, f_dst_x, f_dst_y;
  logic [DIM_IN_W-1:0]   f_width, f_height;
  logic [COLOR_W-1:0]    f_color;

  assign f_src_base   = in_data_i[31:0];
  assign f_src_stride = in_data_i[44:32];
  assign f_dst_base   = in_data_i[76:45];
  assign f_dst_stride = in_data_i[89:77];
  assign f_src_x      = in_data_i[101:90];
  assign f_src_y      = in_data_i[113:102];
  assign f_dst_x      = in_data_i[125:114];
  assign f_dst_y      = in_data_i[137:126];
  assign f_width      = in_data_i[150:138];
  assign f_height     = in_data_i[163:151];
  assign f_color      = in_data_i[195:164];

  assign in_kind = rbf_kind_e'(in_kind_i);

  // The stage frees up whenever its item moves into the queue.
  assign in_ready_o = !vld_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Only ticks and the two start commands carry meaning; the unused code is dropped.
  always_comb begin
    unique case (in_kind)
      KIND_TICK, KIND_BLIT, KIND_FILL: keep = 1'b1;
      default:                         keep = 1'b0;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (push_valid_o && push_ready_i) begin
      vld_d = 1'b0;
    end
    if (accept) begin
      vld_d = keep;
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload stage: one stride-by-row product per surface.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q       <= in_kind;
      src_base_q   <= f_src_base;
      dst_base_q   <= f_dst_base;
      src_stride_q <= f_src_stride;
      dst_stride_q <= f_dst_stride;
      src_x_q      <= f_src_x;
      dst_x_q      <= f_dst_x;
      src_prod_q   <= f_src_stride * f_src_y;
      dst_prod_q   <= f_dst_stride * f_dst_y;
      width_q      <= f_width;
      height_q     <= f_height;
      color_q      <= f_color;
    end
  end

  // Offsets in pixels from the surface base to the rectangle corner.
  assign push_valid_o          = vld_q;
  assign push_cmd_o.kind       = kind_q;
  assign push_cmd_o.src_base   = src_base_q;
  assign push_cmd_o.dst_base   = dst_base_q;
  assign push_cmd_o.src_stride = src_stride_q;
  assign push_cmd_o.dst_stride = dst_stride_q;
  assign push_cmd_o.src_off    = OFF_W'(src_prod_q) + OFF_W'(src_x_q);
  assign push_cmd_o.dst_off    = OFF_W'(dst_prod_q) + OFF_W'(dst_x_q);
  assign push_cmd_o.width      = width_q;
  assign push_cmd_o.height     = height_q;
  assign push_cmd_o.color      = color_q;

endmodule

`default_nettype wire

@@ design/rbf_queue.sv @@
// Short command queue between the front end and the pixel engine.
`default_nettype none

module rbf_queue #(
  parameter int unsigned DEPTH = rbf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire rbf_pkg::rbf_cmd_t push_cmd_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output rbf_pkg::rbf_cmd_t      pop_cmd_o
);
  import rbf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rbf_cmd_t          entries_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entries_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ design/rbf_back.sv @@
// Pixel engine: runs the rectangle walk and issues one pixel access per tick while a rectangle runs.
`default_nettype none

`include "rect_blit_fill_engine_top_macros.svh"

module rbf_back #(
  parameter int unsigned MAX_DIM = rbf_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        pixel_size_mode_i,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_ready_o,
  input  wire rbf_pkg::rbf_cmd_t           cmd_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             out_kind_o,
  output logic [rbf_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                             out_last_o
);
  import rbf_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned SAT_W = (DIM_W > DIM_IN_W) ? DIM_W : DIM_IN_W;

  // Clamp a rectangle dimension to the largest supported size.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_IN_W-1:0] v);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(v);
    if (wide > SAT_W'(MAX_DIM)) begin
      wide = SAT_W'(MAX_DIM);
    end
    return DIM_W'(wide);
  endfunction

  // Walk state.
  logic                  busy_q, busy_d;
  logic                  is_fill_q, is_fill_d;
  logic [DIM_W-1:0]      col_q, col_d;
  logic [DIM_W-1:0]      rows_left_q, rows_left_d;
  logic [DIM_W-1:0]      run_width_q, run_width_d;
  logic [ADDR_W-1:0]     src_row_q, src_row_d;
  logic [ADDR_W-1:0]     dst_row_q, dst_row_d;
  logic [STRIDE_W-1:0]   src_stride_q, src_stride_d;
  logic [STRIDE_W-1:0]   dst_stride_q, dst_stride_d;
  logic [COLOR_W-1:0]    color_q, color_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic                  out_kind_q, out_kind_d;
  logic [ADDR_W-1:0]     out_src_q, out_src_d;
  logic [ADDR_W-1:0]     out_dst_q, out_dst_d;
  logic [COLOR_W-1:0]    out_wdata_q, out_wdata_d;
  logic                  out_last_q, out_last_d;

  logic                  is_start, is_tick, out_free, do_pop, emit;
  logic [1:0]            shamt;
  logic [ADDR_W-1:0]     col_off;
  logic [DIM_W-1:0]      col_inc;
  logic                  row_end, last_px;
  logic [DIM_W-1:0]      new_w, new_h;

  assign is_start = (cmd_i.kind == KIND_BLIT) || (cmd_i.kind == KIND_FILL);
  assign is_tick  = (cmd_i.kind == KIND_TICK);
  assign out_free = !out_valid_q || out_ready_i;

  // A tick that produces a pixel waits for room in the output register.
  assign cmd_ready_o = !(is_tick && busy_q) || out_free;
  assign do_pop      = cmd_valid_i && cmd_ready_o;
  assign emit        = do_pop && is_tick && busy_q;

  assign shamt   = pixel_size_mode_i ? 2'd2 : 2'd0;
  assign col_off = ADDR_W'(col_q) << shamt;
  assign col_inc = col_q + DIM_W'(1);
  assign row_end = (col_inc == run_width_q);
  assign last_px = row_end && (rows_left_q == DIM_W'(1));
  assign new_w   = sat_dim(cmd_i.width);
  assign new_h   = sat_dim(cmd_i.height);

  // Next state of the walk and of the output register.
  always_comb begin
    busy_d       = busy_q;
    is_fill_d    = is_fill_q;
    col_d        = col_q;
    rows_left_d  = rows_left_q;
    run_width_d  = run_width_q;
    src_row_d    = src_row_q;
    dst_row_d    = dst_row_q;
    src_stride_d = src_stride_q;
    dst_stride_d = dst_stride_q;
    color_d      = color_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_src_d    = out_src_q;
    out_dst_d    = out_dst_q;
    out_wdata_d  = out_wdata_q;
    out_last_d   = out_last_q;

    // A start while a rectangle is running is dropped.
    if (do_pop && is_start && !busy_q) begin
      is_fill_d    = (cmd_i.kind == KIND_FILL);
      dst_stride_d = cmd_i.dst_stride;
      dst_row_d    = cmd_i.dst_base + (ADDR_W'(cmd_i.dst_off) << shamt);
      if (cmd_i.kind == KIND_FILL) begin
        color_d      = cmd_i.color;
        src_stride_d = '0;
        src_row_d    = '0;
      end else begin
        color_d      = '0;
        src_stride_d = cmd_i.src_stride;
        src_row_d    = cmd_i.src_base + (ADDR_W'(cmd_i.src_off) << shamt);
      end
      run_width_d = new_w;
      rows_left_d = new_h;
      col_d       = '0;
      busy_d      = (new_w != '0) && (new_h != '0);
    end

    // One pixel access per tick while a rectangle is running.
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = is_fill_q ? ACCESS_FILL : ACCESS_COPY;
      out_src_d   = is_fill_q ? '0 : src_row_q + col_off;
      out_dst_d   = dst_row_q + col_off;
      if (is_fill_q) begin
        out_wdata_d = pixel_size_mode_i ? color_q : (color_q & BYTE_MASK);
      end else begin
        out_wdata_d = '0;
      end
      out_last_d = last_px;
      if (row_end) begin
        col_d       = '0;
        rows_left_d = rows_left_q - DIM_W'(1);
        src_row_d   = src_row_q + (ADDR_W'(src_stride_q) << shamt);
        dst_row_d   = dst_row_q + (ADDR_W'(dst_stride_q) << shamt);
        if (rows_left_q == DIM_W'(1)) begin
          busy_d = 1'b0;
        end
      end else begin
        col_d = col_inc;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      col_q       <= '0;
      rows_left_q <= '0;
      run_width_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      col_q       <= col_d;
      rows_left_q <= rows_left_d;
      run_width_q <= run_width_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload state.
  always_ff @(posedge clk_i) begin
    is_fill_q    <= is_fill_d;
    src_row_q    <= src_row_d;
    dst_row_q    <= dst_row_d;
    src_stride_q <= src_stride_d;
    dst_stride_q <= dst_stride_d;
    color_q      <= color_d;
    out_kind_q   <= out_kind_d;
    out_src_q    <= out_src_d;
    out_dst_q    <= out_dst_d;
    out_wdata_q  <= out_wdata_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = {out_wdata_q, out_dst_q, out_src_q};
  assign out_last_o  = out_last_q;

  // A running rectangle always has rows and columns left to walk.
  `RBF_ASSERT(a_busy_dims, busy_q |-> (rows_left_q != '0 && col_q < run_width_q), "bad walk state")
  // The final pixel of a rectangle ends the walk.
  `RBF_ASSERT(a_last_ends, (emit && last_px) |=> !busy_q, "walk kept running after last pixel")
  // A pixel is only issued into a free output register.
  `RBF_ASSERT(a_no_overrun, emit |-> out_free, "output register overrun")

endmodule

`default_nettype wire

@@ design/rect_blit_fill_engine_top.sv @@
// Top level of the rectangle copy and fill engine: ports, register file and wiring.
`default_nettype none

// A tick item passes the front-end stage, the queue and the pixel engine's output register
// before its pixel access shows. Throughput: one item per cycle while the output is not
// stalled; a running rectangle issues one access per tick item.
// Start items produce no result.
// Reset (async, active low) empties the queue and stages, stops any walk and sets
// pixel_size_mode to four bytes per pixel.

module rect_blit_fill_engine_top #(
  parameter int unsigned MAX_DIM     = rbf_pkg::MAX_DIM_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = rbf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input items.
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: src_base, src_stride, dst_base, dst_stride, src_x, src_y, dst_x, dst_y,
  // rect_width, rect_height, fill_color, zero pad.
  input  wire logic [rbf_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // tuser: kind.
  input  wire logic [rbf_pkg::KIND_W-1:0]    s_axis_tuser_i,
  // Result items.
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata: src_address, dst_address, write_data.
  output logic [rbf_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // tuser: access_kind.
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbf_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rbf_pkg::*;

  logic      pixel_size_mode_q;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  rbf_cmd_t  push_cmd, pop_cmd;
  logic      cfg_wr;

  // Register file: one mode bit, written in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_PIXEL_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_size_mode_q <= 1'b1;
    end else if (cfg_wr) begin
      pixel_size_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_PIXEL_SIZE) ? {31'd0, pixel_size_mode_q} : '0;

  rbf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_kind_i    (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  rbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  rbf_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pixel_size_mode_i (pixel_size_mode_q),
    .cmd_valid_i       (pop_valid),
    .cmd_ready_o       (pop_ready),
    .cmd_i             (pop_cmd),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_kind_o        (m_axis_tuser_o),
    .out_data_o        (m_axis_tdata_o),
    .out_last_o        (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the rectangle copy and fill engine.
`timescale 1ns / 1ps

module tb;
  import rbf_pkg::*;

  localparam int unsigned DIM_LIMIT     = MAX_DIM_DEFAULT;
  localparam int unsigned SETTLE_CYCLES = 3 + QUEUE_DEPTH_DEFAULT + 8;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 1500;
  localparam int unsigned SAT_TICKS     = 64;

  // Kind code that the block has no use for.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Register address and values of the pixel size setting.
  localparam logic [CFG_ADDR_W-1:0] PIXEL_SIZE_ADDR = {CFG_IDX_PIXEL_SIZE, 2'b00};
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_WORD = 1'b1;

  // One command item as it enters the block.
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   src_base;
    logic [STRIDE_W-1:0] src_stride;
    logic [ADDR_W-1:0]   dst_base;
    logic [STRIDE_W-1:0] dst_stride;
    logic [COORD_W-1:0]  src_x;
    logic [COORD_W-1:0]  src_y;
    logic [COORD_W-1:0]  dst_x;
    logic [COORD_W-1:0]  dst_y;
    logic [DIM_IN_W-1:0] width;
    logic [DIM_IN_W-1:0] height;
    logic [COLOR_W-1:0]  color;
  } rect_cmd_t;

  // One pixel access as it leaves the block.
  typedef struct {
    logic        access;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] wdata;
    logic        last;
  } pixel_op_t;

  // Tracks the rectangle walk and holds the pixel accesses still to arrive.
  class rect_walk_model;
    logic        wide = MODE_WORD;
    logic        busy = 1'b0;
    logic        fill = 1'b0;
    int unsigned col = 0;
    int unsigned rows_left = 0;
    int unsigned run_w = 0;
    logic [31:0] src_row = '0;
    logic [31:0] dst_row = '0;
    logic [31:0] src_step = '0;
    logic [31:0] dst_step = '0;
    logic [31:0] color = '0;
    pixel_op_t   pending_ops[$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned starts = 0;

    function void set_mode(logic m);
      wide = m;
    endfunction

    function int unsigned clamp_dim(logic [DIM_IN_W-1:0] v);
      return (v > DIM_LIMIT) ? DIM_LIMIT : int'(v);
    endfunction

    function logic [31:0] pixel_addr(logic [31:0] base, logic [STRIDE_W-1:0] stride,
                                     logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic [31:0] bpp);
      logic [31:0] lin;
      lin = {19'b0, stride} * {20'b0, y} + {20'b0, x};
      return base + lin * bpp;
    endfunction

    // Notes one accepted command and predicts the access it causes, if any.
    function void take_command(rect_cmd_t c);
      pixel_op_t   op;
      logic [31:0] bpp;
      logic [31:0] off;
      bpp = wide ? 32'd4 : 32'd1;
      if (c.kind == KIND_BLIT || c.kind == KIND_FILL) begin
        if (busy) return;
        starts++;
        fill = (c.kind == KIND_FILL);
        dst_step = {19'b0, c.dst_stride};
        dst_row = pixel_addr(c.dst_base, c.dst_stride, c.dst_x, c.dst_y, bpp);
        if (fill) begin
          color = c.color;
          src_step = '0;
          src_row = '0;
        end else begin
          src_step = {19'b0, c.src_stride};
          src_row = pixel_addr(c.src_base, c.src_stride, c.src_x, c.src_y, bpp);
          color = '0;
        end
        run_w = clamp_dim(c.width);
        rows_left = clamp_dim(c.height);
        col = 0;
        busy = (run_w != 0) && (rows_left != 0);
        return;
      end
      if (c.kind != KIND_TICK || !busy) return;

      off = col * bpp;
      op.access = fill ? ACCESS_FILL : ACCESS_COPY;
      op.src_addr = fill ? 32'd0 : src_row + off;
      op.dst_addr = dst_row + off;
      op.wdata = fill ? (wide ? color : (color & BYTE_MASK)) : 32'd0;
      op.last = (col + 1 == run_w) && (rows_left == 1);
      pending_ops.push_back(op);

      // Step to the next column, and to the next row at the end of one.
      col++;
      if (col >= run_w) begin
        col = 0;
        rows_left--;
        src_row += src_step * bpp;
        dst_row += dst_step * bpp;
        if (rows_left == 0) busy = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Compares one received access with the oldest predicted one.
    task check_access(pixel_op_t got);
      pixel_op_t want;
      if (pending_ops.size() == 0) begin
        report($sformatf("access to %h with nothing predicted", got.dst_addr));
        return;
      end
      want = pending_ops.pop_front();
      checked++;
      compare_field("access_kind", {31'b0, got.access}, {31'b0, want.access});
      compare_field("src_address", got.src_addr, want.src_addr);
      compare_field("dst_address", got.dst_addr, want.dst_addr);
      compare_field("write_data", got.wdata, want.wdata);
      compare_field("last_of_rect", {31'b0, got.last}, {31'b0, want.last});
    endtask

    function int unsigned pending_count();
      return pending_ops.size();
    endfunction
  endclass

  logic clk;
  logic rst_ni = 1'b0;

  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire [OUT_DATA_W-1:0]  m_tdata;
  wire                   m_tuser;
  wire                   m_tlast;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  wire [31:0]            prdata;
  wire                   pready;

  rect_walk_model walker = new();

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  bit          quiet = 1'b0;
  bit          hold_pending = 1'b0;
  int unsigned counted_items = 0;
  int unsigned cycle_count = 0;

  rect_blit_fill_engine_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: random stall bursts and one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    pixel_op_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got.access = m_tuser;
      got.src_addr = m_tdata[31:0];
      got.dst_addr = m_tdata[63:32];
      got.wdata = m_tdata[95:64];
      got.last = m_tlast;
      walker.check_access(got);
    end
  end

  // Command with every field random; callers narrow what matters.
  function automatic rect_cmd_t random_cmd(logic [KIND_W-1:0] k);
    rect_cmd_t c;
    c.kind = k;
    c.src_base = $urandom;
    c.src_stride = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
    c.dst_base = $urandom;
    c.dst_stride = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
    c.src_x = 12'($urandom);
    c.src_y = 12'($urandom);
    c.dst_x = 12'($urandom);
    c.dst_y = 12'($urandom);
    c.width = 13'($urandom);
    c.height = 13'($urandom);
    c.color = $urandom;
    return c;
  endfunction

  function automatic logic [KIND_W-1:0] random_start_kind();
    return $urandom_range(0, 1) ? KIND_BLIT : KIND_FILL;
  endfunction

  // Offers one item, waits for acceptance, then maybe idles.
  task automatic send_cmd(rect_cmd_t c);
    s_tvalid <= 1'b1;
    s_tuser <= c.kind;
    s_tdata <= {4'b0, c.color, c.height, c.width, c.dst_y, c.dst_x, c.src_y, c.src_x,
                c.dst_stride, c.dst_base, c.src_stride, c.src_base};
    do @(posedge clk); while (!s_tready);
    walker.take_command(c);
    if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_ticks(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_cmd(random_cmd(KIND_TICK));
  endtask

  // Stops offering items and waits until every predicted access has come.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (walker.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [CFG_ADDR_W-1:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes the pixel size, reads it back and updates the prediction.
  task automatic set_pixel_size(logic mode);
    logic [31:0] rd;
    apb_access(1'b1, PIXEL_SIZE_ADDR, {31'b0, mode}, rd);
    walker.set_mode(mode);
    apb_access(1'b0, PIXEL_SIZE_ADDR, 32'd0, rd);
    if (rd !== {31'b0, mode})
      walker.report($sformatf("pixel_size_mode read %h, expected %h", rd, mode));
  endtask

  // One random stretch: mostly whole rectangles with ticks, some noise.
  task automatic random_phase(int unsigned n_items);
    rect_cmd_t   c;
    int unsigned n_px;
    int unsigned stop_at;
    stop_at = counted_items + n_items;
    while (counted_items < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          c = random_cmd(random_start_kind());
          if ($urandom_range(0, 1)) c.width = '0;
          else c.height = '0;
          send_cmd(c);
          counted_items++;
        end
        1: send_cmd(random_cmd($urandom_range(0, 1) ? KIND_TICK : KIND_UNUSED));
        default: begin
          c = random_cmd(random_start_kind());
          c.width = 13'($urandom_range(1, 8));
          c.height = 13'($urandom_range(1, 5));
          send_cmd(c);
          counted_items++;
          n_px = c.width * c.height;
          for (int unsigned i = 0; i < n_px; i++) begin
            // Occasional start while busy or unused kind mid-walk.
            if ($urandom_range(0, 19) == 0)
              send_cmd(random_cmd($urandom_range(0, 1) ? random_start_kind() : KIND_UNUSED));
            send_cmd(random_cmd(KIND_TICK));
            counted_items++;
          end
        end
      endcase
    end
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    rect_cmd_t   c;
    logic [31:0] rd;

    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset value of the pixel size register.
    apb_access(1'b0, PIXEL_SIZE_ADDR, 32'd0, rd);
    if (rd !== {31'b0, MODE_WORD})
      walker.report($sformatf("pixel_size_mode after reset %h", rd));

    // Directed: idle tick, unused kind, wrapping blit with a start while busy.
    src_idle_pct = 20;
    sink_idle_pct = 20;
    send_cmd(random_cmd(KIND_TICK));
    send_cmd(random_cmd(KIND_UNUSED));
    c = random_cmd(KIND_BLIT);
    c.src_base = 32'hFFFF_FFF0;
    c.src_stride = 13'd4096;
    c.src_x = 12'hFFF;
    c.src_y = 12'hFFF;
    c.dst_base = '0;
    c.dst_stride = 13'd1;
    c.dst_x = '0;
    c.dst_y = '0;
    c.width = 13'd2;
    c.height = 13'd2;
    send_cmd(c);
    send_ticks(1);
    send_cmd(random_cmd(KIND_FILL));
    send_cmd(random_cmd(KIND_UNUSED));
    send_ticks(3);

    // Empty rectangles, one with an oversized other side.
    c = random_cmd(KIND_FILL);
    c.width = '0;
    c.height = 13'd4096;
    send_cmd(c);
    send_ticks(1);
    c = random_cmd(KIND_BLIT);
    c.width = 13'h1FFF;
    c.height = '0;
    send_cmd(c);

    // Zero-stride fill at the top of the address space.
    c = random_cmd(KIND_FILL);
    c.dst_base = 32'hFFFF_FFFF;
    c.dst_stride = '0;
    c.dst_x = 12'hFFF;
    c.dst_y = 12'hFFF;
    c.width = 13'd3;
    c.height = 13'd2;
    c.color = 32'hFFFF_FFFF;
    send_cmd(c);
    send_ticks(6);
    wait_drained();

    // Byte mode fill, then a mode change in the middle of a walk.
    set_pixel_size(MODE_BYTE);
    c = random_cmd(KIND_FILL);
    c.width = 13'd2;
    c.height = 13'd1;
    send_cmd(c);
    send_ticks(2);
    c = random_cmd(KIND_FILL);
    c.width = 13'd3;
    c.height = 13'd3;
    send_cmd(c);
    send_ticks(4);
    wait_drained();
    set_pixel_size(MODE_WORD);
    send_ticks(5);
    wait_drained();

    // Random stretches across both pixel sizes and idle mixes.
    set_pixel_size(MODE_BYTE);
    src_idle_pct = 25;
    sink_idle_pct = 25;
    random_phase(RANDOM_ITEMS / 4);

    set_pixel_size(MODE_WORD);
    src_idle_pct = 10;
    sink_idle_pct = 40;
    random_phase(RANDOM_ITEMS / 4);

    // Receiver holds off while a long fill keeps the input busy.
    set_pixel_size(MODE_BYTE);
    src_idle_pct = 0;
    hold_pending = 1'b1;
    c = random_cmd(KIND_FILL);
    c.width = 13'd32;
    c.height = 13'd4;
    send_cmd(c);
    send_ticks(128);
    wait_drained();
    src_idle_pct = 40;
    sink_idle_pct = 10;
    random_phase(RANDOM_ITEMS / 4);

    set_pixel_size(MODE_WORD);
    quiet = 1'b1;
    random_phase(RANDOM_ITEMS / 4);

    // Oversized width at the end of the run: the first pixels of a saturated row.
    c = random_cmd(KIND_BLIT);
    c.width = 13'h1FFF;
    c.height = 13'd1;
    send_cmd(c);
    send_ticks(SAT_TICKS);
    wait_drained();

    $display("Checked %0d pixel accesses from %0d accepted rectangle starts,",
             walker.checked, walker.starts);
    $display("in both pixel sizes, with stalls on both sides and a long receiver hold.");
    if (walker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
